FILE: hdl/tts_pkg.sv
// Shared types, codes and reset values for the TCP transmit sequencer.
package tts_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned HALF_W   = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned RETRY_W  = 5;
   localparam int unsigned MAXR_W   = 4;

   // Saturation point of the resend counter
   localparam logic [RETRY_W-1:0] RETRY_SAT = 5'd31;

   // Reset values of the configuration registers
   localparam logic [HALF_W-1:0] RESET_REMOTE_MSS  = 16'd536;
   localparam logic [HALF_W-1:0] RESET_LOCAL_MSS   = 16'd1460;
   localparam logic [HALF_W-1:0] RESET_RTO_MS      = 16'd700;
   localparam logic [MAXR_W-1:0] RESET_MAX_RETRY   = 4'd5;
   localparam logic [WORD_W-1:0] RESET_BROKEN_MS   = 32'd600000;

   // Receive advance limit: differences at or above this count as behind
   localparam logic [WORD_W-1:0] HALF_RANGE = 32'h8000_0000;

   typedef enum logic [1:0] {
      OP_POLL     = 2'd0,
      OP_RESEND_ACK = 2'd1,
      OP_RESET    = 2'd2,
      OP_CLOSE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CONN_EMPTY       = 2'd0,
      CONN_SYN_RCVD    = 2'd1,
      CONN_ESTABLISHED = 2'd2,
      CONN_FIN_WAIT    = 2'd3
   } conn_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_SEND = 2'd1,
      ACT_REAP = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOCAL_ISN   = 3'd0,
      CSR_REMOTE_ISN  = 3'd1,
      CSR_REMOTE_MSS  = 3'd2,
      CSR_LOCAL_MSS   = 3'd3,
      CSR_RTO_MS      = 3'd4,
      CSR_MAX_RETRY   = 3'd5,
      CSR_BROKEN_MS   = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [WORD_W-1:0] local_isn;
      logic [WORD_W-1:0] remote_isn;
      logic [HALF_W-1:0] remote_mss;
      logic [HALF_W-1:0] local_mss;
      logic [HALF_W-1:0] rto_ms;
      logic [MAXR_W-1:0] max_retry;
      logic [WORD_W-1:0] broken_ms;
   } cfg_type;

   // Classified request as it waits between front and back
   typedef struct packed {
      op_type            op;
      conn_type          conn;
      logic [WORD_W-1:0] rcvd;
      logic [WORD_W-1:0] peer_acked;
      logic [HALF_W-1:0] window;
      logic [WORD_W-1:0] now;
      logic [HALF_W-1:0] clip_len;
      logic              app_done;
      logic              link_broken;
   } entry_type;

   typedef struct packed {
      action_type        action;
      logic [WORD_W-1:0] seq_number;
      logic [WORD_W-1:0] ack_number;
      logic              syn_flag;
      logic              fin_flag;
      logic              rst_flag;
      logic [HALF_W-1:0] mss_option;
      logic [HALF_W-1:0] data_length;
      logic              app_query;
      logic [WORD_W-1:0] stream_position;
   } result_type;

endpackage

FILE: hdl/tts_channels.sv
// Handshake channels of the TCP transmit sequencer: request, result, register write.
interface tts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [1:0]  conn_state;
   logic [31:0] bytes_received;
   logic [31:0] bytes_acked_by_peer;
   logic        peer_fin_seen;
   logic [15:0] peer_window;
   logic [31:0] now_ms;
   logic [31:0] last_receive_ms;
   logic [15:0] app_length;
   logic        app_done;

   modport source (
      output valid, operation, conn_state, bytes_received, bytes_acked_by_peer,
             peer_fin_seen, peer_window, now_ms, last_receive_ms, app_length, app_done,
      input  ready
   );
   modport sink (
      input  valid, operation, conn_state, bytes_received, bytes_acked_by_peer,
             peer_fin_seen, peer_window, now_ms, last_receive_ms, app_length, app_done,
      output ready
   );
endinterface

interface tts_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] seq_number;
   logic [31:0] ack_number;
   logic        syn_flag;
   logic        fin_flag;
   logic        rst_flag;
   logic [15:0] mss_option;
   logic [15:0] data_length;
   logic        app_query;
   logic [31:0] stream_position;

   modport source (
      output valid, action, seq_number, ack_number, syn_flag, fin_flag, rst_flag,
             mss_option, data_length, app_query, stream_position,
      input  ready
   );
   modport sink (
      input  valid, action, seq_number, ack_number, syn_flag, fin_flag, rst_flag,
             mss_option, data_length, app_query, stream_position,
      output ready
   );
endinterface

interface tts_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/tts_csr.sv
// Configuration register file of the TCP transmit sequencer.
module tts_csr
   import tts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tts_csr_if.sink       csr_bus,
   output cfg_type       cfg
);

   cfg_type cfg_ff;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   // Write the addressed register; ignore indexes past the list
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_isn  <= '0;
         cfg_ff.remote_isn <= '0;
         cfg_ff.remote_mss <= RESET_REMOTE_MSS;
         cfg_ff.local_mss  <= RESET_LOCAL_MSS;
         cfg_ff.rto_ms     <= RESET_RTO_MS;
         cfg_ff.max_retry  <= RESET_MAX_RETRY;
         cfg_ff.broken_ms  <= RESET_BROKEN_MS;
      end else if (csr_bus.valid) begin
         unique case (csr_idx_type'(csr_bus.index))
            CSR_LOCAL_ISN:  cfg_ff.local_isn  <= csr_bus.data;
            CSR_REMOTE_ISN: cfg_ff.remote_isn <= csr_bus.data;
            CSR_REMOTE_MSS: cfg_ff.remote_mss <= csr_bus.data[HALF_W-1:0];
            CSR_LOCAL_MSS:  cfg_ff.local_mss  <= csr_bus.data[HALF_W-1:0];
            CSR_RTO_MS:     cfg_ff.rto_ms     <= csr_bus.data[HALF_W-1:0];
            CSR_MAX_RETRY:  cfg_ff.max_retry  <= csr_bus.data[MAXR_W-1:0];
            CSR_BROKEN_MS:  cfg_ff.broken_ms  <= csr_bus.data;
            default: ;
         endcase
      end
   end

endmodule

FILE: hdl/tts_front.sv
// Front end: accepts requests and classifies them into queue entries.
module tts_front
   import tts_pkg::*;
(
   tts_req_if.sink   req_bus,
   input  cfg_type   cfg,
   output logic      push_valid,
   input  logic      push_ready,
   output entry_type push_entry
);

   logic [WORD_W-1:0] idle_ms;

   assign req_bus.ready = push_ready;
   assign push_valid    = req_bus.valid;

   // Work out everything that needs no connection state
   always_comb begin
      idle_ms                = req_bus.now_ms - req_bus.last_receive_ms;
      push_entry.op          = op_type'(req_bus.operation);
      push_entry.conn        = conn_type'(req_bus.conn_state);
      push_entry.rcvd        = req_bus.bytes_received;
      push_entry.peer_acked  = req_bus.bytes_acked_by_peer;
      push_entry.window      = req_bus.peer_window;
      push_entry.now         = req_bus.now_ms;
      push_entry.clip_len    = (req_bus.app_length < cfg.remote_mss) ?
                               req_bus.app_length : cfg.remote_mss;
      push_entry.app_done    = req_bus.app_done;
      push_entry.link_broken = (idle_ms >= cfg.broken_ms);
   end

endmodule

FILE: hdl/tts_queue.sv
// Two-entry queue between the front end and the back end.
module tts_queue
   import tts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Store the incoming entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

FILE: hdl/tts_back.sv
// Back end: connection state, send/resend/reap decision and result register.
module tts_back
   import tts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  entry_type pop_entry,
   tts_rsp_if.source rsp_bus
);

   logic [WORD_W-1:0]  bytes_sent_ff,  bytes_sent_in;
   logic [WORD_W-1:0]  acked_to_ff,    acked_to_in;
   logic               fin_sent_ff,    fin_sent_in;
   logic [WORD_W-1:0]  timer_ff,       timer_in;
   logic [RETRY_W-1:0] retry_ff,       retry_in;
   result_type         rsp_ff,         rsp_in;
   logic               rsp_valid_ff;

   logic               take;
   logic               all_acked;
   logic [WORD_W-1:0]  timer_base;
   logic [RETRY_W-1:0] retry_base;
   logic [RETRY_W-1:0] retry_bump;
   logic               rto_hit;
   logic [WORD_W-1:0]  rcv_diff;
   logic               advanced;
   logic               win_ok;
   logic [HALF_W:0]    seg_count;
   logic [WORD_W-1:0]  ack_now;
   logic [WORD_W-1:0]  seq_now;
   entry_type          e;

   assign e         = pop_entry;
   assign take      = pop_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign pop_ready = !rsp_valid_ff || rsp_bus.ready;

   // Timer, resend and receive-advance checks
   always_comb begin
      all_acked  = (bytes_sent_ff == e.peer_acked);
      timer_base = all_acked ? e.now : timer_ff;
      retry_base = all_acked ? '0 : retry_ff;
      retry_bump = (retry_base < RETRY_SAT) ? retry_base + 1'b1 : retry_base;
      rto_hit    = ((e.now - timer_base) >= {{(WORD_W-HALF_W){1'b0}}, cfg.rto_ms});
      rcv_diff   = e.rcvd - acked_to_ff;
      advanced   = (rcv_diff != '0) && (rcv_diff < HALF_RANGE);
      win_ok     = ((bytes_sent_ff - e.peer_acked) < {{(WORD_W-HALF_W){1'b0}}, e.window});
      ack_now    = acked_to_ff + cfg.remote_isn;
      seq_now    = bytes_sent_ff + cfg.local_isn;
   end

   // Decide the result and the next connection state
   always_comb begin
      bytes_sent_in = bytes_sent_ff;
      acked_to_in   = acked_to_ff;
      fin_sent_in   = fin_sent_ff;
      timer_in      = timer_ff;
      retry_in      = retry_ff;
      rsp_in        = '0;
      rsp_in.action = ACT_NONE;
      seg_count     = '0;
      unique case (e.op)
         OP_POLL: begin
            priority if (e.conn == CONN_EMPTY) begin
               rsp_in.action = ACT_NONE;
            end else if (e.link_broken) begin
               rsp_in.action = ACT_REAP;
            end else if (rto_hit) begin
               retry_in = retry_bump;
               if (retry_bump > {1'b0, cfg.max_retry}) begin
                  timer_in      = timer_base;
                  rsp_in.action = ACT_REAP;
               end else begin
                  // Resend from the peer's acknowledged position
                  timer_in          = e.now;
                  rsp_in.action     = ACT_SEND;
                  rsp_in.ack_number = ack_now;
                  rsp_in.seq_number = e.peer_acked + cfg.local_isn;
                  if (e.conn == CONN_SYN_RCVD) begin
                     rsp_in.syn_flag   = 1'b1;
                     rsp_in.mss_option = cfg.local_mss;
                  end else begin
                     rsp_in.app_query       = 1'b1;
                     rsp_in.stream_position = e.peer_acked - 1'b1;
                     rsp_in.data_length     = e.clip_len;
                     if (e.app_done) begin
                        rsp_in.fin_flag = 1'b1;
                        fin_sent_in     = 1'b1;
                     end
                  end
               end
            end else begin
               // Normal send: SYN, data (with FIN when the app is done), or bare ACK; no result if nothing is due
               timer_in = timer_base;
               retry_in = retry_base;
               if (e.conn == CONN_SYN_RCVD && bytes_sent_ff == '0) begin
                  rsp_in.syn_flag   = 1'b1;
                  rsp_in.mss_option = cfg.local_mss;
               end
               if (e.conn == CONN_ESTABLISHED && !fin_sent_ff && win_ok) begin
                  rsp_in.app_query       = 1'b1;
                  rsp_in.stream_position = bytes_sent_ff - 1'b1;
                  rsp_in.data_length     = e.clip_len;
                  if (e.app_done) begin
                     rsp_in.fin_flag = 1'b1;
                     fin_sent_in     = 1'b1;
                  end
               end
               seg_count = {1'b0, rsp_in.data_length} +
                           {{HALF_W{1'b0}}, rsp_in.syn_flag} +
                           {{HALF_W{1'b0}}, rsp_in.fin_flag};
               acked_to_in   = e.rcvd;
               bytes_sent_in = bytes_sent_ff + {{(WORD_W-HALF_W-1){1'b0}}, seg_count};
               rsp_in.ack_number = e.rcvd + cfg.remote_isn;
               rsp_in.seq_number = seq_now;
               if (!advanced && seg_count == '0) begin
                  rsp_in = '0;
                  rsp_in.action = ACT_NONE;
               end else begin
                  rsp_in.action = ACT_SEND;
               end
            end
         end
         OP_RESEND_ACK, OP_RESET: begin
            rsp_in.action     = ACT_SEND;
            rsp_in.ack_number = ack_now;
            rsp_in.seq_number = seq_now;
            rsp_in.rst_flag   = (e.op == OP_RESET);
         end
         OP_CLOSE: begin
            rsp_in.action     = ACT_SEND;
            rsp_in.fin_flag   = 1'b1;
            rsp_in.ack_number = ack_now;
            rsp_in.seq_number = seq_now;
            fin_sent_in       = 1'b1;
            bytes_sent_in     = bytes_sent_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // Hold connection state; advance it on each request taken
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_sent_ff <= '0;
         acked_to_ff   <= '0;
         fin_sent_ff   <= 1'b0;
         timer_ff      <= '0;
         retry_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            bytes_sent_ff <= bytes_sent_in;
            acked_to_ff   <= acked_to_in;
            fin_sent_ff   <= fin_sent_in;
            timer_ff      <= timer_in;
            retry_ff      <= retry_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.action          = rsp_ff.action;
   assign rsp_bus.seq_number      = rsp_ff.seq_number;
   assign rsp_bus.ack_number      = rsp_ff.ack_number;
   assign rsp_bus.syn_flag        = rsp_ff.syn_flag;
   assign rsp_bus.fin_flag        = rsp_ff.fin_flag;
   assign rsp_bus.rst_flag        = rsp_ff.rst_flag;
   assign rsp_bus.mss_option      = rsp_ff.mss_option;
   assign rsp_bus.data_length     = rsp_ff.data_length;
   assign rsp_bus.app_query       = rsp_ff.app_query;
   assign rsp_bus.stream_position = rsp_ff.stream_position;

endmodule

FILE: hdl/tcp_transmit_sequencer.sv
// Throughput is one request per clock cycle while results are taken. A request is registered
// in a queue slot and then in the result register: the front end classifies a request (link
// timeout, length clip) as it enters a two-entry queue, and the back end takes one queued
// request per cycle unless a result waits unread, updating the connection counters and timer in
// that same cycle and loading the result register. The back end's state update sets the rate.
// Requests keep flowing while a result waits; when both the result register and the queue
// are full, req_bus.ready drops. Register writes on csr_bus are always taken.
module tcp_transmit_sequencer
   import tts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tts_req_if.sink   req_bus,
   tts_rsp_if.source rsp_bus,
   tts_csr_if.sink   csr_bus
);

   cfg_type   cfg;
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   tts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   tts_front u_front (
      .req_bus    (req_bus),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   tts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   tts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_bus   (rsp_bus)
   );

endmodule
